// File: rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the button debounce and event classifier:
// register map, register reset values, configuration and result records.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // configuration register width and apb address width
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd15;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd500;
  localparam logic [CFG_W-1:0] FIRST_HOLD_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] REPEAT_HOLD_RST  = 16'd1000;

  // register index, taken from paddr word bits
  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_SHORT_MAX    = 3'd1,
    REG_DOUBLE_CLICK = 3'd2,
    REG_FIRST_HOLD   = 3'd3,
    REG_REPEAT_HOLD  = 3'd4
  } reg_idx_t;

  // configuration as seen by the classifier core
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] short_max_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [CFG_W-1:0] first_hold_ms;
    logic [CFG_W-1:0] repeat_hold_ms;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic        press_start;
    logic        short_press;
    logic        long_press;
    logic        double_click;
    logic        release_event;
    logic        hold_timeout;
    logic [15:0] press_duration;
    logic [15:0] hold_elapsed;
    logic        stable_level;
  } result_t;

endpackage

// File: rtl/bdc_if.sv
// ----------------------------------------------------------------------------
// bdc_if
// Valid/ready channels of the classifier: raw sample in, event record out.
// ----------------------------------------------------------------------------
interface bdc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdc_out_if;
  logic        valid;
  logic        ready;
  logic        press_start;
  logic        short_press;
  logic        long_press;
  logic        double_click;
  logic        release_event;
  logic        hold_timeout;
  logic [15:0] press_duration;
  logic [15:0] hold_elapsed;
  logic        stable_level;

  modport source (
    output valid, input ready,
    output press_start, output short_press, output long_press, output double_click,
    output release_event, output hold_timeout, output press_duration,
    output hold_elapsed, output stable_level
  );
  modport sink (
    input valid, output ready,
    input press_start, input short_press, input long_press, input double_click,
    input release_event, input hold_timeout, input press_duration,
    input hold_elapsed, input stable_level
  );
endinterface

// File: rtl/bdc_regs.sv
// ----------------------------------------------------------------------------
// bdc_regs
// APB register file holding the five timing thresholds of the classifier.
// ----------------------------------------------------------------------------
module bdc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0] paddr,
  input  logic [bdc_pkg::DATA_W-1:0] pwdata,
  output logic [bdc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bdc_pkg::cfg_t              cfg
);
  import bdc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  // decode
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes, low half of the data word only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= DEBOUNCE_RST;
      cfg_r.short_max_ms    <= SHORT_MAX_RST;
      cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
      cfg_r.first_hold_ms   <= FIRST_HOLD_RST;
      cfg_r.repeat_hold_ms  <= REPEAT_HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:     cfg_r.debounce_ms     <= pwdata[CFG_W-1:0];
        REG_SHORT_MAX:    cfg_r.short_max_ms    <= pwdata[CFG_W-1:0];
        REG_DOUBLE_CLICK: cfg_r.double_click_ms <= pwdata[CFG_W-1:0];
        REG_FIRST_HOLD:   cfg_r.first_hold_ms   <= pwdata[CFG_W-1:0];
        REG_REPEAT_HOLD:  cfg_r.repeat_hold_ms  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:     prdata = DATA_W'(cfg_r.debounce_ms);
      REG_SHORT_MAX:    prdata = DATA_W'(cfg_r.short_max_ms);
      REG_DOUBLE_CLICK: prdata = DATA_W'(cfg_r.double_click_ms);
      REG_FIRST_HOLD:   prdata = DATA_W'(cfg_r.first_hold_ms);
      REG_REPEAT_HOLD:  prdata = DATA_W'(cfg_r.repeat_hold_ms);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/bdc_core.sv
// ----------------------------------------------------------------------------
// bdc_core
// Debounce filter, press/hold timers and event decode. One sample is folded
// into the state on each cycle that step_en is high; the result is
// combinational from the current state and the sample.
// ----------------------------------------------------------------------------
module bdc_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              sample,
  input  bdc_pkg::cfg_t     cfg,
  output bdc_pkg::result_t  res
);
  import bdc_pkg::*;

  localparam int unsigned TW = TIMER_WIDTH;
  // compare width covers both timers and 16-bit thresholds
  localparam int unsigned CW = (TW > CFG_W) ? TW : CFG_W;
  localparam logic [TW-1:0] TMAX = '1;

  // timer and level state
  logic [TW-1:0] press_timer_r, press_timer_nxt;
  logic [TW-1:0] hold_timer_r, hold_timer_nxt;
  logic [TW-1:0] gap_timer_r, gap_timer_nxt;
  logic [TW-1:0] deb_count_r, deb_count_nxt;
  logic          filt_level_r, filt_level_nxt;
  // stable level; the previous stable level always equals it between samples
  logic          deb_level_r, deb_level_nxt;
  logic          hold_rep_r, hold_rep_nxt;
  logic [CW-1:0] hold_total_r, hold_total_nxt;

  // per-sample intermediates
  logic [TW-1:0] press_inc, hold_inc, gap_inc, deb_inc;
  logic          stable_ok, edge_det, press_det, rel_det, short_det, dbl_det;
  logic          hold_fire, rep_mid;
  logic [TW-1:0] hold_mid;
  logic [CW-1:0] total_mid;
  logic [CFG_W-1:0] hold_limit;
  logic [CW:0]   total_sum;
  logic [CW-1:0] total_add;

  // saturating increments
  assign press_inc = (press_timer_r == TMAX) ? TMAX : press_timer_r + 1'b1;
  assign hold_inc  = (hold_timer_r  == TMAX) ? TMAX : hold_timer_r  + 1'b1;
  assign gap_inc   = (gap_timer_r   == TMAX) ? TMAX : gap_timer_r   + 1'b1;
  assign deb_inc   = (deb_count_r   == TMAX) ? TMAX : deb_count_r   + 1'b1;

  // debounce filter
  assign deb_count_nxt  = (sample != filt_level_r) ? '0 : deb_inc;
  assign filt_level_nxt = sample;
  assign stable_ok      = CW'(deb_count_nxt) >= CW'(cfg.debounce_ms);
  assign deb_level_nxt  = stable_ok ? sample : deb_level_r;

  // stable edges and release classification
  assign edge_det  = stable_ok && (sample != deb_level_r);
  assign press_det = edge_det && !sample;
  assign rel_det   = edge_det && sample;
  assign short_det = rel_det && (CW'(press_inc) <= CW'(cfg.short_max_ms));
  assign dbl_det   = short_det && (gap_inc != TMAX) &&
                     (CW'(gap_inc) <= CW'(cfg.double_click_ms));

  // hold tracking, restarted by a press in the same sample
  assign hold_mid   = press_det ? '0 : hold_inc;
  assign rep_mid    = press_det ? 1'b0 : hold_rep_r;
  assign total_mid  = press_det ? CW'(cfg.first_hold_ms) : hold_total_r;
  assign hold_limit = rep_mid ? cfg.repeat_hold_ms : cfg.first_hold_ms;
  assign hold_fire  = stable_ok && !sample && (CW'(hold_mid) >= CW'(hold_limit));

  // saturating accumulate of hold time
  assign total_sum = {1'b0, total_mid} + (CW+1)'(cfg.repeat_hold_ms);
  assign total_add = (total_sum >= (CW+1)'(TMAX)) ? CW'(TMAX) : total_sum[CW-1:0];

  // next state
  assign press_timer_nxt = press_det ? '0 : press_inc;
  assign hold_timer_nxt  = hold_fire ? '0 : hold_mid;
  assign gap_timer_nxt   = short_det ? '0 : gap_inc;
  assign hold_rep_nxt    = hold_fire ? 1'b1 : rep_mid;
  assign hold_total_nxt  = hold_fire ? total_add : total_mid;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_timer_r <= '0;
      hold_timer_r  <= '0;
      gap_timer_r   <= TMAX;
      deb_count_r   <= '0;
      filt_level_r  <= 1'b1;
      deb_level_r   <= 1'b1;
      hold_rep_r    <= 1'b0;
      hold_total_r  <= '0;
    end else if (step_en) begin
      press_timer_r <= press_timer_nxt;
      hold_timer_r  <= hold_timer_nxt;
      gap_timer_r   <= gap_timer_nxt;
      deb_count_r   <= deb_count_nxt;
      filt_level_r  <= filt_level_nxt;
      deb_level_r   <= deb_level_nxt;
      hold_rep_r    <= hold_rep_nxt;
      hold_total_r  <= hold_total_nxt;
    end
  end

  // result record, durations clamped to 16 bits
  always_comb begin
    res = '0;
    res.press_start   = press_det;
    res.short_press   = short_det;
    res.long_press    = rel_det && !short_det;
    res.double_click  = dbl_det;
    res.release_event = rel_det;
    res.hold_timeout  = hold_fire;
    res.stable_level  = deb_level_nxt;
    if (rel_det && !short_det) begin
      res.press_duration = (CW'(press_inc) > CW'(16'hFFFF)) ? 16'hFFFF
                                                           : 16'(press_inc);
    end
    if (hold_fire) begin
      res.hold_elapsed = (total_mid > CW'(16'hFFFF)) ? 16'hFFFF : total_mid[15:0];
    end
  end

  // a new press always restarts the hold timer
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && press_det) |=> (hold_timer_r == '0 || hold_rep_r))
    else $error("hold timer not restarted on press");

  // no hold timeout while released
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && hold_fire) |-> !deb_level_nxt)
    else $error("hold timeout while released");

  // a short press restarts the click gap
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && short_det) |=> (gap_timer_r == '0))
    else $error("click gap not restarted");

endmodule

// File: rtl/button_debounce_event_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_event_classifier
// Debounced button with press, short/long release, double click and
// repeating hold timeout events; thresholds set over APB.
// ----------------------------------------------------------------------------
// Accepts one raw sample per cycle while the output is not stalled and
// returns exactly one event record for each sample: the sample lands in an
// input register, the whole debounce and timer update is one pass of logic,
// and the record lands in the output register; apart from stalls the rate
// is limited only by that single-pass state update. Both sides may stall
// freely; write registers only when no sample is in flight, which the block
// itself does not enforce. Timers are TIMER_WIDTH bits wide and saturate.
module button_debounce_event_classifier #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bdc_in_if.sink                     in_chan,
  bdc_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0] paddr,
  input  logic [bdc_pkg::DATA_W-1:0] pwdata,
  output logic [bdc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bdc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_item_r;
  logic    out_valid_r;
  logic    in_valid_r;
  logic    in_pin_r;
  logic    advance;

  // register file
  bdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline flow: the held sample moves on when the output slot frees up
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_pin_r <= in_chan.pin_level;
    end
  end

  // classifier state and decode
  bdc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .sample  (in_pin_r),
    .cfg     (cfg),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  // output channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.press_start    = out_item_r.press_start;
  assign out_chan.short_press    = out_item_r.short_press;
  assign out_chan.long_press     = out_item_r.long_press;
  assign out_chan.double_click   = out_item_r.double_click;
  assign out_chan.release_event  = out_item_r.release_event;
  assign out_chan.hold_timeout   = out_item_r.hold_timeout;
  assign out_chan.press_duration = out_item_r.press_duration;
  assign out_chan.hold_elapsed   = out_item_r.hold_elapsed;
  assign out_chan.stable_level   = out_item_r.stable_level;

  // short and long release are exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.short_press && out_item_r.long_press))
    else $error("short and long press together");

  // a double click is always a short press with a release
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.double_click) |->
      (out_item_r.short_press && out_item_r.release_event))
    else $error("double click without short release");

  // a processed sample always produces a record in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost");

  // press start only with the pressed stable level
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.press_start) |->
      (!out_item_r.stable_level && !out_item_r.release_event))
    else $error("press start with released level");

endmodule

// File: sim/button_debounce_event_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_event_classifier_tb
// Self-checking bench for the button debouncer and event classifier. Raw
// samples go in over the valid/ready input channel while registers are set
// over APB between phases; a cycle-level predictor runs on every accepted
// sample and each event record leaving the block is compared field by field
// against the oldest predicted record. Covers reset values, a short directed
// click/hold sequence, the register map, random bouncy press sequences under
// several settings, extreme settings and hold total saturation.
// ----------------------------------------------------------------------------
module button_debounce_event_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdc_pkg::*;

  localparam logic [15:0] TICK_MAX     = 16'hFFFF;
  localparam logic [2:0]  REG_UNMAPPED = 3'd5;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned PIPE_SLACK   = 6;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bdc_in_if  in_if ();
  bdc_out_if out_if ();

  button_debounce_event_classifier dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register shadow and classifier state of the predictor
  cfg_t        cfg_shadow;
  logic        sample_last;
  logic [15:0] steady_ticks;
  logic        level_now;
  logic        level_prev;
  logic [15:0] press_ticks;
  logic [15:0] hold_ticks;
  logic        repeating;
  logic [15:0] hold_sum;
  logic [15:0] gap_ticks;

  // event records predicted but not yet seen
  result_t     events_due[$];

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == TICK_MAX) ? TICK_MAX : v + 16'd1;
  endfunction

  // one tick of debounce, edge classification and hold timing
  function automatic result_t classify_sample(input logic pin);
    result_t     r;
    logic [15:0] limit_ticks;
    logic [16:0] sum;
    r = '0;
    press_ticks = bump(press_ticks);
    hold_ticks  = bump(hold_ticks);
    gap_ticks   = bump(gap_ticks);
    if (pin != sample_last) begin
      sample_last  = pin;
      steady_ticks = '0;
    end else begin
      steady_ticks = bump(steady_ticks);
    end
    if (steady_ticks >= cfg_shadow.debounce_ms) begin
      level_now = sample_last;
      if (level_now != level_prev) begin
        if (!level_now) begin
          // press edge restarts the press and hold timing
          press_ticks   = '0;
          hold_ticks    = '0;
          repeating     = 1'b0;
          hold_sum      = cfg_shadow.first_hold_ms;
          r.press_start = 1'b1;
        end else begin
          // release edge: short or long by press length
          if (press_ticks <= cfg_shadow.short_max_ms) begin
            if (gap_ticks != TICK_MAX && gap_ticks <= cfg_shadow.double_click_ms) begin
              r.double_click = 1'b1;
            end
            gap_ticks     = '0;
            r.short_press = 1'b1;
          end else begin
            r.long_press     = 1'b1;
            r.press_duration = press_ticks;
          end
          r.release_event = 1'b1;
        end
        level_prev = level_now;
      end
      // hold timeout while pressed, first interval then repeat interval
      if (!level_now) begin
        limit_ticks = repeating ? cfg_shadow.repeat_hold_ms : cfg_shadow.first_hold_ms;
        if (hold_ticks >= limit_ticks) begin
          r.hold_timeout = 1'b1;
          r.hold_elapsed = hold_sum;
          repeating      = 1'b1;
          sum            = {1'b0, hold_sum} + {1'b0, cfg_shadow.repeat_hold_ms};
          hold_sum       = sum[16] ? TICK_MAX : sum[15:0];
          hold_ticks     = '0;
        end
      end
    end
    r.stable_level = level_now;
    return r;
  endfunction

  // apb write, shadow follows the low half of the data
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {junk, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DEBOUNCE:     cfg_shadow.debounce_ms     = val;
      REG_SHORT_MAX:    cfg_shadow.short_max_ms    = val;
      REG_DOUBLE_CLICK: cfg_shadow.double_click_ms = val;
      REG_FIRST_HOLD:   cfg_shadow.first_hold_ms   = val;
      REG_REPEAT_HOLD:  cfg_shadow.repeat_hold_ms  = val;
      default: ;
    endcase
  endtask

  task automatic read_reg(input logic [2:0] idx, output logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // read back every register against the shadow
  task automatic verify_registers();
    logic [DATA_W-1:0] rd;
    logic [15:0]       want;
    reg_idx_t          idx;
    idx = idx.first();
    repeat (idx.num()) begin
      read_reg(idx, rd);
      case (idx)
        REG_DEBOUNCE:     want = cfg_shadow.debounce_ms;
        REG_SHORT_MAX:    want = cfg_shadow.short_max_ms;
        REG_DOUBLE_CLICK: want = cfg_shadow.double_click_ms;
        REG_FIRST_HOLD:   want = cfg_shadow.first_hold_ms;
        default:          want = cfg_shadow.repeat_hold_ms;
      endcase
      if (rd[15:0] !== want) begin
        flag_mismatch($sformatf("register %s reads %0h, want %0h", idx.name(), rd[15:0], want));
      end
      idx = idx.next();
    end
  endtask

  // stop sending and wait for every outstanding record
  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_if.valid = 1'b0;
    while (events_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t c);
    wait_for_drain();
    write_reg(REG_DEBOUNCE, c.debounce_ms);
    write_reg(REG_SHORT_MAX, c.short_max_ms);
    write_reg(REG_DOUBLE_CLICK, c.double_click_ms);
    write_reg(REG_FIRST_HOLD, c.first_hold_ms);
    write_reg(REG_REPEAT_HOLD, c.repeat_hold_ms);
  endtask

  // one sample transaction, sent in bursts with random gaps between them
  task automatic send_sample(input logic pin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.pin_level = pin;
    do @(posedge clk); while (!in_if.ready);
    events_due.push_back(classify_sample(pin));
  endtask

  // optional bounce, then a steady level
  task automatic run_level(input logic lvl, input int unsigned bounce, input int unsigned span);
    repeat (bounce) send_sample(1'($urandom_range(0, 1)));
    repeat (span) send_sample(lvl);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("record %0d %s got %0h want %0h", results_seen, name, got, want));
    end
  endtask

  // receiver stalls in modes of random length
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    mode_left    = 0;
    mode         = RX_FREE;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: mode = RX_FREE;
          5, 6, 7:       mode = RX_CHOPPY;
          default:       mode = RX_SLOW;
        endcase
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        RX_FREE:   out_if.ready = 1'b1;
        RX_CHOPPY: out_if.ready = 1'($urandom_range(0, 1));
        default:   out_if.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each record transaction with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (events_due.size() == 0) begin
        flag_mismatch($sformatf("record %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = events_due.pop_front();
        cmp_field("press_start", 16'(out_if.press_start), 16'(want.press_start));
        cmp_field("short_press", 16'(out_if.short_press), 16'(want.short_press));
        cmp_field("long_press", 16'(out_if.long_press), 16'(want.long_press));
        cmp_field("double_click", 16'(out_if.double_click), 16'(want.double_click));
        cmp_field("release_event", 16'(out_if.release_event), 16'(want.release_event));
        cmp_field("hold_timeout", 16'(out_if.hold_timeout), 16'(want.hold_timeout));
        cmp_field("press_duration", out_if.press_duration, want.press_duration);
        cmp_field("hold_elapsed", out_if.hold_elapsed, want.hold_elapsed);
        cmp_field("stable_level", 16'(out_if.stable_level), 16'(want.stable_level));
      end
      results_seen++;
    end
  end

  // reset values readable, short bounce under the default filter
  task automatic test_reset_state();
    verify_registers();
    run_level(1'b0, 0, 1);
    run_level(1'b1, 0, 1);
    run_level(1'b0, 0, 1);
  endtask

  // press with bounce, hold timeouts, long release, short then double click;
  // the first short press sees the saturated click gap under the widest window
  task automatic test_directed_events();
    cfg_t        c;
    logic [0:18] taps;
    c    = '{debounce_ms: 16'd1, short_max_ms: 16'd3, double_click_ms: TICK_MAX,
             first_hold_ms: 16'd2, repeat_hold_ms: 16'd1};
    taps = 19'b0100000110011001111;
    apply_setting(c);
    for (int i = 0; i < 19; i++) begin
      send_sample(taps[i]);
    end
  endtask

  // unmapped index ignored, upper data bits dropped
  task automatic test_register_map();
    wait_for_drain();
    write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
    verify_registers();
  endtask

  // bouncy press and release sequences under random small settings
  task automatic test_random_sequences();
    cfg_t        c;
    int unsigned sent;
    int unsigned span;
    int unsigned bounce;
    logic        lvl;
    for (int ph = 0; ph < 3; ph++) begin
      c.debounce_ms     = 16'($urandom_range(1, 4));
      c.short_max_ms    = 16'($urandom_range(0, 20));
      c.double_click_ms = 16'($urandom_range(0, 30));
      c.first_hold_ms   = 16'($urandom_range(1, 20));
      c.repeat_hold_ms  = 16'($urandom_range(1, 8));
      apply_setting(c);
      sent = 0;
      lvl  = level_now;
      while (sent < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          // pure noise
          span = $urandom_range(1, 6);
          run_level(1'b0, span, 0);
          sent += span;
        end else begin
          lvl    = ~lvl;
          bounce = $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) begin
            // too short to pass the filter
            span = $urandom_range(1, c.debounce_ms);
          end else if (!lvl && $urandom_range(0, 1) == 0) begin
            span = c.debounce_ms + $urandom_range(0, c.short_max_ms + 2);
          end else if (!lvl) begin
            span = c.debounce_ms + $urandom_range(0, c.first_hold_ms + 3 * c.repeat_hold_ms);
          end else begin
            span = c.debounce_ms + $urandom_range(0, c.double_click_ms + 4);
          end
          run_level(lvl, bounce, span);
          sent += bounce + span;
        end
        // occasionally let everything come out before going on
        if ($urandom_range(0, 59) == 0) begin
          wait_for_drain();
        end
      end
    end
  endtask

  // all registers at their largest, then the short and double click windows at zero and the rest at one
  task automatic test_extreme_settings();
    cfg_t c;
    c = '{debounce_ms: TICK_MAX, short_max_ms: TICK_MAX, double_click_ms: TICK_MAX,
          first_hold_ms: TICK_MAX, repeat_hold_ms: TICK_MAX};
    apply_setting(c);
    run_level(1'b0, 12, 8);
    c = '{debounce_ms: 16'd1, short_max_ms: 16'd0, double_click_ms: 16'd0,
          first_hold_ms: 16'd1, repeat_hold_ms: 16'd1};
    apply_setting(c);
    run_level(1'b1, 0, 3);
    run_level(1'b0, 1, 5);
    run_level(1'b1, 1, 3);
    run_level(1'b0, 0, 3);
    run_level(1'b1, 2, 4);
    wait_for_drain();
    verify_registers();
  endtask

  // hold total starts near the top at the press, then the thresholds drop
  // mid-hold so it saturates and keeps reporting the saturated value
  task automatic test_saturation();
    cfg_t c;
    c = '{debounce_ms: 16'd2, short_max_ms: 16'd1000, double_click_ms: TICK_MAX,
          first_hold_ms: 16'd65000, repeat_hold_ms: 16'd1000};
    apply_setting(c);
    run_level(1'b1, 0, 4);
    run_level(1'b0, 2, 4);
    wait_for_drain();
    write_reg(REG_FIRST_HOLD, 16'd1);
    run_level(1'b0, 0, 3);
    wait_for_drain();
    write_reg(REG_REPEAT_HOLD, 16'd1);
    run_level(1'b0, 0, 4);
    run_level(1'b1, 1, 6);
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.pin_level = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_n           = 1'b0;

    // predictor at its reset state
    cfg_shadow   = '{debounce_ms: DEBOUNCE_RST, short_max_ms: SHORT_MAX_RST,
                     double_click_ms: DOUBLE_CLICK_RST, first_hold_ms: FIRST_HOLD_RST,
                     repeat_hold_ms: REPEAT_HOLD_RST};
    sample_last  = 1'b1;
    steady_ticks = '0;
    level_now    = 1'b1;
    level_prev   = 1'b1;
    press_ticks  = '0;
    hold_ticks   = '0;
    repeating    = 1'b0;
    hold_sum     = '0;
    gap_ticks    = TICK_MAX;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_events();
    test_register_map();
    test_random_sequences();
    test_extreme_settings();
    test_saturation();

    wait_for_drain();
    if (events_due.size() != 0) begin
      flag_mismatch($sformatf("%0d records never arrived", events_due.size()));
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bdc_pkg.sv
rtl/bdc_if.sv
rtl/bdc_regs.sv
rtl/bdc_core.sv
rtl/button_debounce_event_classifier.sv
sim/button_debounce_event_classifier_tb.sv
